// ===== src/pse_pkg.sv =====
// Package for the postfix stack evaluator: symbol codes, flag layout and shared types.
// Used by pse_divider and postfix_stack_evaluator.
package pse_pkg;

   localparam logic [7:0] SYM_ZERO  = 8'h30;
   localparam logic [7:0] SYM_NINE  = 8'h39;
   localparam logic [7:0] SYM_SPACE = 8'h20;
   localparam logic [7:0] SYM_TAB   = 8'h09;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_MINUS = 8'h2D;
   localparam logic [7:0] SYM_MUL   = 8'h2A;
   localparam logic [7:0] SYM_DIV   = 8'h2F;
   localparam logic [7:0] SYM_MOD   = 8'h25;
   localparam logic [7:0] SYM_POW   = 8'h24;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP_R,
      ST_WAIT_R,
      ST_POP_L,
      ST_WAIT_L,
      ST_EXEC,
      ST_DIV,
      ST_POW,
      ST_PUSH,
      ST_FINAL,
      ST_FINAL_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic bad;
      logic div0;
      logic over;
      logic under;
   } flags_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctrl_type;

endpackage

// ===== src/pse_divider.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on pse_pkg for the control struct.
module pse_divider
   import pse_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output div_ctrl_type       ctrl,
   output logic        [31:0] quotient,
   output logic        [31:0] remainder
);

   logic [31:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         quo_in  = dividend[31] ? 32'(-dividend) : dividend;
         den_in  = divisor[31] ? 32'(-divisor) : divisor;
         rem_in  = '0;
         cnt_in  = 6'd32;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign quotient   = qneg_ff ? 32'(-quo_ff) : quo_ff;
   assign remainder  = rneg_ff ? 32'(-rem_ff[31:0]) : rem_ff[31:0];

endmodule

// ===== src/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator: stack memory, sequencer and arithmetic.
// Depends on pse_pkg and pse_divider.
//
// Usage: each req word carries one ASCII character in req_tdata and req_tlast marks the
// last character of an expression. Digits push, operators pop two words and push the
// result; space and tab are skipped. After the last character the top of the stack is
// popped and sent on the rsp channel with the sticky fault flags in rsp_tuser, and the
// stack and flags are cleared for the next expression.
// Sequence: a blank returns straight to idle, a digit goes through the push state and an
// unknown character is flagged in the first pop state; + - * pop both operands, execute
// and push; / and % also pass the divide state for the 32-step divider, which a zero
// divisor skips. $ runs one square-and-multiply step per cycle over the exponent bits.
// The final pop passes ST_FINAL, ST_FINAL_WAIT and ST_OUT, and the result word then
// waits in the output register until taken. The stack is a synchronous single-port
// memory with a registered read; each pop is a read followed by a wait state.
// Reset clears the fill count, flags, output valid and sequencer; stack contents need no clearing.
// A stalled rsp side holds the block before it takes the next req word.
module postfix_stack_evaluator
   import pse_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic [3:0]  rsp_tuser,   // [0] underflow [1] overflow [2] divide_by_zero [3] bad_symbol
   output logic        rsp_tlast
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW = $clog2(STACK_DEPTH + 1);
   localparam logic [FW-1:0] FULL = FW'(STACK_DEPTH);

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_ff;
   logic        mem_we;
   logic [AW-1:0] mem_addr;
   logic [31:0] mem_wd;

   state_type   state_ff, state_in;
   logic [FW-1:0] fill_ff, fill_in;
   flags_type   flags_ff, flags_in;
   logic [7:0]  sym_ff, sym_in;
   logic        last_ff, last_in;
   logic [31:0] r_ff, r_in, l_ff, l_in, res_ff, res_in;
   logic        rv_ff, rv_in, lv_ff, lv_in;
   logic [31:0] pb_ff, pb_in, pe_ff, pe_in;
   logic        out_v_ff, out_v_in;
   logic [31:0] out_d_ff, out_d_in;
   logic [3:0]  out_f_ff, out_f_in;
   logic        div_start;
   div_ctrl_type div_ctrl;
   logic [31:0] quo, rem;
   logic        is_digit, is_op;

   pse_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(l_ff), .divisor(r_ff),
      .ctrl(div_ctrl), .quotient(quo), .remainder(rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      rd_ff <= mem[mem_addr];
   end

   assign is_digit = (req_tdata >= SYM_ZERO) && (req_tdata <= SYM_NINE);
   assign is_op = (sym_ff == SYM_PLUS) || (sym_ff == SYM_MINUS) || (sym_ff == SYM_MUL) ||
                  (sym_ff == SYM_DIV) || (sym_ff == SYM_MOD) || (sym_ff == SYM_POW);
   assign req_tready = (state_ff == ST_IDLE) && !out_v_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      flags_in = flags_ff;
      sym_in   = sym_ff;
      last_in  = last_ff;
      r_in     = r_ff;
      l_in     = l_ff;
      rv_in    = rv_ff;
      lv_in    = lv_ff;
      res_in   = res_ff;
      pb_in    = pb_ff;
      pe_in    = pe_ff;
      out_v_in = out_v_ff;
      out_d_in = out_d_ff;
      out_f_in = out_f_ff;
      mem_we   = 1'b0;
      mem_addr = fill_ff[AW-1:0];
      mem_wd   = res_ff;
      div_start = 1'b0;
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               sym_in  = req_tdata;
               last_in = req_tlast;
               if (is_digit) begin
                  res_in   = {24'd0, req_tdata - SYM_ZERO};
                  state_in = ST_PUSH;
               end else if (req_tdata == SYM_SPACE || req_tdata == SYM_TAB) begin
                  state_in = req_tlast ? ST_FINAL : ST_IDLE;
               end else begin
                  state_in = ST_POP_R;
               end
            end
         end
         ST_POP_R: begin
            if (!is_op) begin
               flags_in.bad = 1'b1;
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else if (flags_ff.bad) begin
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else if (fill_ff == '0) begin
               flags_in.under = 1'b1;
               rv_in = 1'b0;
               state_in = ST_POP_L;
            end else begin
               fill_in  = fill_ff - 1'b1;
               mem_addr = AW'(fill_ff - 1'b1);
               rv_in = 1'b1;
               state_in = ST_WAIT_R;
            end
         end
         ST_WAIT_R: state_in = ST_POP_L;
         ST_POP_L: begin
            r_in = rv_ff ? rd_ff : 32'd0;
            if (fill_ff == '0) begin
               flags_in.under = 1'b1;
               lv_in = 1'b0;
               state_in = ST_EXEC;
            end else begin
               fill_in  = fill_ff - 1'b1;
               mem_addr = AW'(fill_ff - 1'b1);
               lv_in = 1'b1;
               state_in = ST_WAIT_L;
            end
         end
         ST_WAIT_L: state_in = ST_EXEC;
         ST_EXEC: begin
            l_in = lv_ff ? rd_ff : 32'd0;
            state_in = ST_PUSH;
            case (sym_ff)
               SYM_PLUS:  res_in = l_in + r_ff;
               SYM_MINUS: res_in = l_in - r_ff;
               SYM_MUL:   res_in = 32'(l_in * r_ff);
               SYM_DIV, SYM_MOD: begin
                  if (r_ff == '0) begin
                     flags_in.div0 = 1'b1;
                     res_in = '0;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
               default: begin
                  // Power: a negative exponent is settled here, else square and multiply.
                  if (r_ff[31]) begin
                     state_in = ST_PUSH;
                     if (l_in == 32'd1) res_in = 32'd1;
                     else if (l_in == 32'hFFFF_FFFF)
                        res_in = r_ff[0] ? 32'hFFFF_FFFF : 32'd1;
                     else res_in = '0;
                  end else begin
                     res_in = 32'd1;
                     pb_in  = l_in;
                     pe_in  = r_ff;
                     state_in = ST_POW;
                  end
               end
            endcase
         end
         ST_DIV: begin
            // The divider is started in the first ST_DIV cycle, once the left operand is held in l_ff.
            if (!div_ctrl.busy && !div_ctrl.done && !rv_ff) begin
               res_in = res_ff;
            end
            if (div_ctrl.done) begin
               res_in = (sym_ff == SYM_DIV) ? quo : rem;
               state_in = ST_PUSH;
               rv_in = 1'b0;
            end else if (!div_ctrl.busy && !rv_ff) begin
               div_start = 1'b1;
               rv_in = 1'b1;
            end else if (!div_ctrl.busy && rv_ff) begin
               div_start = 1'b1;
               rv_in = 1'b0;
            end
         end
         ST_POW: begin
            if (pe_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               if (pe_ff[0]) res_in = 32'(res_ff * pb_ff);
               pb_in = 32'(pb_ff * pb_ff);
               pe_in = pe_ff >> 1;
            end
         end
         ST_PUSH: begin
            if (fill_ff >= FULL) begin
               flags_in.over = 1'b1;
            end else begin
               mem_we  = 1'b1;
               fill_in = fill_ff + 1'b1;
            end
            state_in = last_ff ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            // The fill count drops so that the wait cycle keeps reading the same entry.
            if (fill_ff == '0) begin
               flags_in.under = 1'b1;
               rv_in = 1'b0;
            end else begin
               fill_in  = fill_ff - 1'b1;
               mem_addr = AW'(fill_ff - 1'b1);
               rv_in = 1'b1;
            end
            state_in = ST_FINAL_WAIT;
         end
         ST_FINAL_WAIT: state_in = ST_OUT;
         ST_OUT: begin
            out_v_in = 1'b1;
            out_d_in = rv_ff ? rd_ff : 32'd0;
            out_f_in = {flags_ff.bad, flags_ff.div0, flags_ff.over, flags_ff.under};
            fill_in  = '0;
            flags_in = '0;
            rv_in    = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sym_ff   <= sym_in;
      last_ff  <= last_in;
      r_ff     <= r_in;
      l_ff     <= l_in;
      lv_ff    <= lv_in;
      res_ff   <= res_in;
      pb_ff    <= pb_in;
      pe_ff    <= pe_in;
      out_d_ff <= out_d_in;
      out_f_ff <= out_f_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         flags_ff <= '0;
         rv_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         flags_ff <= flags_in;
         rv_ff    <= rv_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_f_ff;
   assign rsp_tlast  = 1'b1;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset) fill_ff <= FULL)
      else $error("stack fill beyond depth");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   a_out_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |=> fill_ff == '0 && flags_ff == '0)
      else $error("stack not cleared after result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE && !div_ctrl.busy)
      else $error("input taken while busy");

endmodule
